// File: hdl/rekd_pkg.sv
// shared types, constants and the quadrature lookup for the rotary encoder key decoder
package rekd_pkg;

    localparam int DebounceMaxDef = 8;

    // register reset values
    localparam logic [3:0]  EdgesPerStepRst  = 4'd4;
    localparam logic [15:0] LongpressRst     = 16'd800;
    localparam logic [15:0] SuperlongRst     = 16'd5000;
    localparam logic [15:0] ClickWindowRst   = 16'd300;
    localparam logic [15:0] AccelMidMsRst    = 16'd120;
    localparam logic [15:0] AccelFastMsRst   = 16'd60;
    localparam logic [6:0]  AccelMidStepRst  = 7'd4;
    localparam logic [6:0]  AccelFastStepRst = 7'd16;

    localparam logic [1:0]  MaxClicks = 2'd3;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_FETCH_DETENT,
        CMD_FETCH_ACCEL,
        CMD_FETCH_EVENT
    } t_command;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_CLICK,
        EV_DOUBLE,
        EV_TRIPLE,
        EV_LONG,
        EV_SUPER_LONG
    } t_key_event;

    typedef enum logic [2:0] {
        CFG_EDGES_PER_STEP,
        CFG_LONGPRESS_MS,
        CFG_SUPERLONG_MS,
        CFG_CLICK_WINDOW_MS,
        CFG_ACCEL_MID_MS,
        CFG_ACCEL_FAST_MS,
        CFG_ACCEL_MID_STEP,
        CFG_ACCEL_FAST_STEP
    } t_cfg_index;

    typedef struct packed {
        logic [3:0]  edges_per_step;
        logic [15:0] longpress_ms;
        logic [15:0] superlong_ms;
        logic [15:0] click_window_ms;
        logic [15:0] accel_mid_ms;
        logic [15:0] accel_fast_ms;
        logic [6:0]  accel_mid_step;
        logic [6:0]  accel_fast_step;
    } t_cfg;

    // index is {previous ab, current ab}
    function automatic logic signed [1:0] quad_dir(input logic [3:0] idx);
        logic signed [1:0] d;
        unique case (idx)
            4'd1, 4'd7, 4'd8, 4'd14:  d = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
            default:                  d = 2'sd0;
        endcase
        return d;
    endfunction

endpackage

// File: hdl/rekd_qdec.sv
// quadrature edge decode, detent counting and accelerated delta
module rekd_qdec import rekd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  t_command           i_command,
    input  logic               i_primed,
    input  logic               i_pin_a,
    input  logic               i_pin_b,
    input  t_cfg               i_cfg,
    output logic signed [7:0]  o_detent_count,
    output logic signed [15:0] o_accel_count
);

    logic [1:0]         r_prev_ab, n_prev_ab;
    logic signed [5:0]  r_edge_sum, n_edge_sum;
    logic [7:0]         r_detent_acc, n_detent_acc;
    logic [15:0]        r_accel_acc, n_accel_acc;
    logic [15:0]        r_tick_count, n_tick_count;
    logic [15:0]        r_last_detent, n_last_detent;

    logic               tick;
    logic [1:0]         ab;
    logic signed [1:0]  dir;
    logic [3:0]         eps;
    logic signed [5:0]  eps_s;
    logic signed [5:0]  sum;
    logic [15:0]        tick_inc;
    logic [15:0]        dt;
    logic [15:0]        step;
    logic               clr_detent;
    logic               clr_accel;

    always_comb begin
        tick     = i_fire && (i_command == CMD_TICK);
        ab       = {i_pin_a, i_pin_b};
        dir      = quad_dir({r_prev_ab, ab});
        eps      = (i_cfg.edges_per_step == 4'd0) ? 4'd1 : i_cfg.edges_per_step;
        eps_s    = $signed({2'b00, eps});
        sum      = r_edge_sum + {{4{dir[1]}}, dir};
        tick_inc = r_tick_count + 16'd1;
        dt       = tick_inc - r_last_detent;
        if (dt <= i_cfg.accel_fast_ms) begin
            step = {9'd0, i_cfg.accel_fast_step};
        end else if (dt <= i_cfg.accel_mid_ms) begin
            step = {9'd0, i_cfg.accel_mid_step};
        end else begin
            step = 16'd1;
        end

        n_prev_ab     = r_prev_ab;
        n_edge_sum    = r_edge_sum;
        n_detent_acc  = r_detent_acc;
        n_accel_acc   = r_accel_acc;
        n_tick_count  = r_tick_count;
        n_last_detent = r_last_detent;

        if (tick) begin
            n_prev_ab = ab;
            if (i_primed) begin
                n_tick_count = tick_inc;
                if (dir != 2'sd0) begin
                    n_edge_sum = sum;
                    if (sum >= eps_s) begin
                        n_edge_sum    = sum - eps_s;
                        n_last_detent = tick_inc;
                        n_detent_acc  = r_detent_acc + 8'd1;
                        n_accel_acc   = r_accel_acc + step;
                    end else if (sum <= -eps_s) begin
                        n_edge_sum    = sum + eps_s;
                        n_last_detent = tick_inc;
                        n_detent_acc  = r_detent_acc - 8'd1;
                        n_accel_acc   = r_accel_acc - step;
                    end
                end
            end
        end

        clr_detent = i_fire && ((i_command == CMD_FETCH_DETENT) ||
                                (i_command == CMD_FETCH_ACCEL));
        clr_accel  = i_fire && (i_command == CMD_FETCH_ACCEL);
    end

    assign o_detent_count = $signed(n_detent_acc);
    assign o_accel_count  = $signed(n_accel_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_ab     <= '0;
            r_edge_sum    <= '0;
            r_detent_acc  <= '0;
            r_accel_acc   <= '0;
            r_tick_count  <= '0;
            r_last_detent <= '0;
        end else begin
            r_prev_ab     <= n_prev_ab;
            r_edge_sum    <= n_edge_sum;
            r_detent_acc  <= clr_detent ? 8'd0 : n_detent_acc;
            r_accel_acc   <= clr_accel ? 16'd0 : n_accel_acc;
            r_tick_count  <= n_tick_count;
            r_last_detent <= n_last_detent;
        end
    end

endmodule

// File: hdl/rekd_key.sv
// key debounce, press length measurement and click resolution
module rekd_key import rekd_pkg::*; #(
    parameter int DEBOUNCE_MAX = DebounceMaxDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  t_command   i_command,
    input  logic       i_primed,
    input  logic       i_key_level,
    input  t_cfg       i_cfg,
    output logic [2:0] o_key_event
);

    localparam int         DebW   = $clog2(DEBOUNCE_MAX + 1);
    localparam logic [DebW-1:0] DebMax = DebW'(DEBOUNCE_MAX);

    logic [DebW-1:0] r_deb, n_deb;
    logic            r_key_steady, n_key_steady;
    logic            r_key_prev, n_key_prev;
    logic [15:0]     r_press_len, n_press_len;
    logic [15:0]     r_click_wait, n_click_wait;
    logic [1:0]      r_clicks, n_clicks;
    t_key_event      r_pending, n_pending;

    logic tick;
    logic pressed;
    logic clr_event;

    always_comb begin
        tick      = i_fire && (i_command == CMD_TICK);
        pressed   = ~i_key_level;
        clr_event = i_fire && (i_command == CMD_FETCH_EVENT);

        n_deb        = r_deb;
        n_key_steady = r_key_steady;
        n_key_prev   = r_key_prev;
        n_press_len  = r_press_len;
        n_click_wait = r_click_wait;
        n_clicks     = r_clicks;
        n_pending    = r_pending;

        if (tick && !i_primed) begin
            // first tick only captures the key level
            n_key_steady = pressed;
            n_key_prev   = pressed;
        end else if (tick) begin
            // integrating debounce
            if (pressed) begin
                if (r_deb < DebMax) begin
                    n_deb = r_deb + 1'b1;
                end
            end else if (r_deb != '0) begin
                n_deb = r_deb - 1'b1;
            end
            if (n_deb == '0) begin
                n_key_steady = 1'b0;
            end else if (n_deb >= DebMax) begin
                n_key_steady = 1'b1;
            end

            // press length and release classification
            if (n_key_steady) begin
                if (r_press_len < i_cfg.superlong_ms) begin
                    n_press_len = r_press_len + 16'd1;
                end
            end else if (r_key_prev) begin
                if (r_press_len >= i_cfg.superlong_ms) begin
                    n_clicks     = 2'd0;
                    n_click_wait = 16'd0;
                    if (r_pending == EV_NONE) begin
                        n_pending = EV_SUPER_LONG;
                    end
                end else if (r_press_len >= i_cfg.longpress_ms) begin
                    n_clicks     = 2'd0;
                    n_click_wait = 16'd0;
                    if (r_pending == EV_NONE) begin
                        n_pending = EV_LONG;
                    end
                end else if (r_press_len != 16'd0) begin
                    if (r_clicks < MaxClicks) begin
                        n_clicks = r_clicks + 2'd1;
                    end
                    n_click_wait = 16'd0;
                end
                n_press_len = 16'd0;
            end
            n_key_prev = n_key_steady;

            // click window expiry
            if (!n_key_steady && (n_clicks != 2'd0)) begin
                if (n_click_wait < i_cfg.click_window_ms) begin
                    n_click_wait = n_click_wait + 16'd1;
                end else if (n_pending == EV_NONE) begin
                    n_pending    = t_key_event'({1'b0, n_clicks});
                    n_clicks     = 2'd0;
                    n_click_wait = 16'd0;
                end
            end
        end
    end

    assign o_key_event = n_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb        <= '0;
            r_key_steady <= 1'b0;
            r_key_prev   <= 1'b0;
            r_press_len  <= '0;
            r_click_wait <= '0;
            r_clicks     <= '0;
            r_pending    <= EV_NONE;
        end else begin
            r_deb        <= n_deb;
            r_key_steady <= n_key_steady;
            r_key_prev   <= n_key_prev;
            r_press_len  <= n_press_len;
            r_click_wait <= n_click_wait;
            r_clicks     <= n_clicks;
            r_pending    <= clr_event ? EV_NONE : n_pending;
        end
    end

endmodule

// File: hdl/rotary_encoder_key_event_decoder.sv
// top level: input register, encoder and key units, configuration and result register
// a transaction passes through the input register and then the result register
// throughput: one per cycle without a stall, set by the single state update in the unit stage
// an input register and the result register form a skid pair, so one more transaction
// is taken while a result is stalled
// reset: synchronous active low, clears all counters, the pending event and config to defaults
module rotary_encoder_key_event_decoder import rekd_pkg::*; #(
    parameter int DEBOUNCE_MAX = DebounceMaxDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item channel in
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_command,
    input  logic               i_pin_a,
    input  logic               i_pin_b,
    input  logic               i_key_level,
    // result channel out
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [7:0]  o_detent_count,
    output logic signed [15:0] o_accel_count,
    output logic [2:0]         o_key_event,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    // input register stage
    logic               r_in_valid;
    t_command           r_in_command;
    logic               r_in_pin_a;
    logic               r_in_pin_b;
    logic               r_in_key_level;

    // result register
    logic               r_out_valid;
    logic signed [7:0]  r_out_detent;
    logic signed [15:0] r_out_accel;
    logic [2:0]         r_out_event;

    // configuration registers
    t_cfg               r_cfg;

    // set once the first tick has captured pin levels
    logic               r_primed;

    logic               out_blocked;
    logic               fire;
    logic signed [7:0]  detent_next;
    logic signed [15:0] accel_next;
    logic [2:0]         event_next;

    // result waits on a stalled consumer; the input register only stalls when it is also full
    assign out_blocked = r_out_valid && i_stall;
    assign o_stall     = r_in_valid && out_blocked;
    assign fire        = r_in_valid && !out_blocked;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_command   <= t_command'(i_command);
            r_in_pin_a     <= i_pin_a;
            r_in_pin_b     <= i_pin_b;
            r_in_key_level <= i_key_level;
        end
    end

    // primed flag: the first tick only captures levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
        end else if (fire && (r_in_command == CMD_TICK)) begin
            r_primed <= 1'b1;
        end
    end

    // config write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.edges_per_step  <= EdgesPerStepRst;
            r_cfg.longpress_ms    <= LongpressRst;
            r_cfg.superlong_ms    <= SuperlongRst;
            r_cfg.click_window_ms <= ClickWindowRst;
            r_cfg.accel_mid_ms    <= AccelMidMsRst;
            r_cfg.accel_fast_ms   <= AccelFastMsRst;
            r_cfg.accel_mid_step  <= AccelMidStepRst;
            r_cfg.accel_fast_step <= AccelFastStepRst;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_EDGES_PER_STEP:  r_cfg.edges_per_step  <= i_cfg_data[3:0];
                CFG_LONGPRESS_MS:    r_cfg.longpress_ms    <= i_cfg_data;
                CFG_SUPERLONG_MS:    r_cfg.superlong_ms    <= i_cfg_data;
                CFG_CLICK_WINDOW_MS: r_cfg.click_window_ms <= i_cfg_data;
                CFG_ACCEL_MID_MS:    r_cfg.accel_mid_ms    <= i_cfg_data;
                CFG_ACCEL_FAST_MS:   r_cfg.accel_fast_ms   <= i_cfg_data;
                CFG_ACCEL_MID_STEP:  r_cfg.accel_mid_step  <= i_cfg_data[6:0];
                CFG_ACCEL_FAST_STEP: r_cfg.accel_fast_step <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // encoder path: edges, detents and accelerated delta
    rekd_qdec u_qdec (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_command      (r_in_command),
        .i_primed       (r_primed),
        .i_pin_a        (r_in_pin_a),
        .i_pin_b        (r_in_pin_b),
        .i_cfg          (r_cfg),
        .o_detent_count (detent_next),
        .o_accel_count  (accel_next)
    );

    // key path: debounce, press timing and click resolution
    rekd_key #(
        .DEBOUNCE_MAX (DEBOUNCE_MAX)
    ) u_key (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_command   (r_in_command),
        .i_primed    (r_primed),
        .i_key_level (r_in_key_level),
        .i_cfg       (r_cfg),
        .o_key_event (event_next)
    );

    // result register, values shown before any fetch clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_blocked) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_detent <= detent_next;
            r_out_accel  <= accel_next;
            r_out_event  <= event_next;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_detent_count = r_out_detent;
    assign o_accel_count  = r_out_accel;
    assign o_key_event    = r_out_event;

`ifndef SYNTHESIS
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled without both stages full");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("processed transaction produced no result");

    a_blocked_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_blocked |=> (r_out_valid && $stable(r_out_event) && $stable(r_out_accel)))
        else $error("stalled result register changed");

    a_primed_after_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (r_in_command == CMD_TICK)) |=> r_primed)
        else $error("tick did not prime the decoder");
`endif

endmodule
